// ===== rtl/prm_pkg.sv =====
// Shared package of the packet rate monitor: field widths, register indexes,
// reset values, alarm constants, state machine encodings and the divider request.
// Has no dependencies; every other file of the block uses it by scoped names.
package prm_pkg;

	localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

	localparam int TS_W      = 48;
	localparam int LEN_W     = 19;
	localparam int TOTAL_W   = 48;
	localparam int BIT_TOT_W = 51;
	localparam int ICNT_W    = 16;
	localparam int IBITS_W   = 36;
	localparam int RATE_W    = 32;
	localparam int RATE_WIDE = 40;
	localparam int ALARM_W   = 7;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [15:0] BATCH_SIZE_RST     = 16'd10;
	localparam logic [31:0] MAX_INTERVAL_RST   = 32'd100000;
	localparam logic [31:0] THRESHOLD_PPS_RST  = 32'd100;
	localparam logic [15:0] HOLD_INTERVALS_RST = 16'd100;

	localparam logic [RATE_W-1:0]  LOAD_RATE_MIN   = 32'd3000;
	localparam logic [ALARM_W-1:0] LOAD_FIRE_COUNT = 7'd100;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BATCH_SIZE     = 3'd0,
		REG_MAX_INTERVAL   = 3'd1,
		REG_THRESHOLD_PPS  = 3'd2,
		REG_HOLD_INTERVALS = 3'd3,
		REG_LOAD_ENABLE    = 3'd4,
		REG_THRESH_ENABLE  = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DECIDE,
		ST_RATE_REQ,
		ST_RATE_WAIT,
		ST_COUNT,
		ST_CHECK,
		ST_WRITE
	} top_state_t;

	typedef enum logic [1:0] {
		RATE_BITS,
		RATE_PACKETS,
		RATE_MAL,
		RATE_BEN
	} rate_sel_t;

	typedef enum logic [2:0] {
		DIV_IDLE,
		DIV_MUL_LO,
		DIV_MUL_HI,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic start;
		logic wide;
	} div_req_t;

endpackage

// ===== rtl/prm_rate_div.sv =====
// Shared rate unit: floor(count * TICKS_PER_SECOND / duration), saturated to 32 or 40 bits.
// Two multiply steps on count halves, then one restoring division bit per cycle.
// Depends on prm_pkg.
module prm_rate_div #(
	parameter int unsigned TICKS_PER_SECOND = prm_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  prm_pkg::div_req_t               req,
	input  logic [prm_pkg::IBITS_W-1:0]     count,
	input  logic [prm_pkg::TS_W-1:0]        dur,
	output logic                            done,
	output logic [prm_pkg::RATE_WIDE-1:0]   result
);

	localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int HALF_W = prm_pkg::IBITS_W / 2;
	localparam int MUL_W  = HALF_W + TPS_W;
	localparam int PROD_W = prm_pkg::IBITS_W + TPS_W;
	localparam int STEP_W = $clog2(PROD_W);
	localparam int DUR_W  = prm_pkg::TS_W;
	localparam int RES_W  = prm_pkg::RATE_WIDE;
	localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);

	prm_pkg::div_state_t state_q, state_d;

	logic [prm_pkg::IBITS_W-1:0] cnt_q;
	logic [DUR_W-1:0]            dur_q;
	logic                        wide_q;
	logic [PROD_W-1:0]           num_q;
	logic [DUR_W-1:0]            rem_q;
	logic [STEP_W-1:0]           step_q;
	logic [RES_W-1:0]            res_q;

	logic [HALF_W-1:0] mul_a;
	logic [MUL_W-1:0]  prod;
	logic [DUR_W:0]    trial;
	logic [DUR_W:0]    diff;
	logic              ge;
	logic [PROD_W-1:0] num_next;

	function automatic logic [RES_W-1:0] cap_of(input logic wide);
		return wide ? {RES_W{1'b1}} : {{(RES_W - prm_pkg::RATE_W){1'b0}},
			{prm_pkg::RATE_W{1'b1}}};
	endfunction

	assign mul_a    = (state_q == prm_pkg::DIV_MUL_HI) ?
		cnt_q[prm_pkg::IBITS_W-1:HALF_W] : cnt_q[HALF_W-1:0];
	assign prod     = MUL_W'(mul_a) * MUL_W'(TPS_C);
	assign trial    = {rem_q, num_q[PROD_W-1]};
	assign ge       = trial >= {1'b0, dur_q};
	assign diff     = trial - {1'b0, dur_q};
	assign num_next = {num_q[PROD_W-2:0], ge};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prm_pkg::DIV_IDLE: begin
				if (req.start) begin
					if (count == '0 || dur == '0)
						state_d = prm_pkg::DIV_DONE;
					else
						state_d = prm_pkg::DIV_MUL_LO;
				end
			end
			prm_pkg::DIV_MUL_LO: state_d = prm_pkg::DIV_MUL_HI;
			prm_pkg::DIV_MUL_HI: state_d = prm_pkg::DIV_RUN;
			prm_pkg::DIV_RUN: begin
				if (step_q == '0)
					state_d = prm_pkg::DIV_DONE;
			end
			prm_pkg::DIV_DONE: state_d = prm_pkg::DIV_IDLE;
			default: state_d = prm_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == prm_pkg::DIV_DONE);
		result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prm_pkg::DIV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == prm_pkg::DIV_MUL_HI)
				step_q <= STEP_W'(PROD_W - 1);
			else if (state_q == prm_pkg::DIV_RUN)
				step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			prm_pkg::DIV_IDLE: begin
				if (req.start) begin
					cnt_q  <= count;
					dur_q  <= dur;
					wide_q <= req.wide;
					res_q  <= (count == '0) ? '0 : cap_of(req.wide);
				end
			end
			prm_pkg::DIV_MUL_LO: begin
				num_q <= {{HALF_W{1'b0}}, prod};
				rem_q <= '0;
			end
			prm_pkg::DIV_MUL_HI: begin
				num_q <= num_q + {prod, {HALF_W{1'b0}}};
			end
			prm_pkg::DIV_RUN: begin
				rem_q <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
				num_q <= num_next;
				if (step_q == '0) begin
					if (wide_q)
						res_q <= (|num_next[PROD_W-1:RES_W]) ? cap_of(1'b1) :
							num_next[RES_W-1:0];
					else
						res_q <= (|num_next[PROD_W-1:prm_pkg::RATE_W]) ? cap_of(1'b0) :
							RES_W'(num_next[prm_pkg::RATE_W-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("rate unit done held for more than one cycle");

	a_rem_below_dur: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prm_pkg::DIV_RUN |-> rem_q < dur_q)
		else $error("division remainder not below the divisor");

	a_narrow_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done && !wide_q |-> result[RES_W-1:prm_pkg::RATE_W] == '0)
		else $error("narrow rate exceeds 32 bits");
`endif

endmodule

// ===== rtl/packet_rate_monitor_alarm.sv =====
// Top level of the packet rate monitor with load alarm and threshold flag.
// Holds the configuration registers, running totals, the sequencer and the output register.
// Depends on prm_pkg and prm_rate_div.
//
// An item that does not close the measurement interval passes through the EVAL, DECIDE,
// COUNT, CHECK and WRITE states before the next input transfer. An item that closes the
// interval additionally runs the shared rate unit four times in a row (bit, packet,
// malicious and benign rates), each run computing PROD_W quotient bits, where PROD_W is 36
// plus the bit width of TICKS_PER_SECOND (56 at the default); a rate whose count or
// duration is zero skips the multiply and division steps. The rate unit retires one quotient
// bit per cycle, which sets the close time. A finished result sits in the output register,
// so the next input transfer is taken while the result still waits for the consumer.
module packet_rate_monitor_alarm #(
	parameter int unsigned TICKS_PER_SECOND = prm_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [prm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [prm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [prm_pkg::TS_W-1:0]          timestamp,
	input  logic [prm_pkg::LEN_W-1:0]         bit_length,
	input  logic                              is_malicious,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [prm_pkg::TOTAL_W-1:0]       total_packets,
	output logic [prm_pkg::TOTAL_W-1:0]       total_bytes,
	output logic [prm_pkg::RATE_W-1:0]        current_pps,
	output logic [prm_pkg::RATE_WIDE-1:0]     current_bps,
	output logic [prm_pkg::RATE_W-1:0]        malicious_pps,
	output logic [prm_pkg::RATE_W-1:0]        benign_pps,
	output logic                              threshold_flag,
	output logic                              load_event,
	output logic                              load_alarm_latched
);

	localparam int TS_W    = prm_pkg::TS_W;
	localparam int ICNT_W  = prm_pkg::ICNT_W;
	localparam int IBITS_W = prm_pkg::IBITS_W;
	localparam int BT_W    = prm_pkg::BIT_TOT_W;

	prm_pkg::top_state_t state_q, state_d;
	prm_pkg::rate_sel_t  sel_q;

	logic [15:0] batch_size_q;
	logic [31:0] max_interval_q;
	logic [31:0] threshold_pps_q;
	logic [15:0] hold_intervals_q;
	logic        load_en_q;
	logic        thresh_en_q;

	logic [prm_pkg::TOTAL_W-1:0] packet_total_q;
	logic [BT_W-1:0]             bit_total_q;
	logic [TS_W-1:0]             interval_start_q;
	logic [ICNT_W-1:0]           ipackets_q;
	logic [ICNT_W-1:0]           imal_q;
	logic [ICNT_W-1:0]           iben_q;
	logic [IBITS_W-1:0]          ibits_q;
	logic [prm_pkg::RATE_W-1:0]  rate_packets_q;
	logic [prm_pkg::RATE_WIDE-1:0] rate_bits_q;
	logic [prm_pkg::RATE_W-1:0]  rate_mal_q;
	logic [prm_pkg::RATE_W-1:0]  rate_ben_q;
	logic [prm_pkg::ALARM_W-1:0] alarm_count_q;
	logic                        alarm_latched_q;
	logic [15:0]                 hold_count_q;
	logic                        flag_value_q;
	logic                        close_q;
	logic                        prev_flag_q;
	logic                        event_q;
	logic                        out_valid_q;

	logic [TS_W-1:0]                  ts_q;
	logic [prm_pkg::LEN_W-1:0]        len_q;
	logic                             mal_q;
	logic [TS_W-1:0]                  dur_q;
	logic [prm_pkg::TOTAL_W-1:0]      total_packets_q;
	logic [prm_pkg::TOTAL_W-1:0]      total_bytes_q;
	logic [prm_pkg::RATE_W-1:0]       current_pps_q;
	logic [prm_pkg::RATE_WIDE-1:0]    current_bps_q;
	logic [prm_pkg::RATE_W-1:0]       malicious_pps_q;
	logic [prm_pkg::RATE_W-1:0]       benign_pps_q;
	logic                             threshold_flag_q;
	logic                             load_event_q;
	logic                             load_latched_q;

	prm_pkg::div_req_t             div_req;
	logic [IBITS_W-1:0]            div_count;
	logic                          div_done;
	logic [prm_pkg::RATE_WIDE-1:0] div_result;

	logic               in_xfer;
	logic               out_load;
	logic [BT_W:0]      bit_sum;
	logic [IBITS_W:0]   ibits_sum;
	logic [TS_W-1:0]    dur_calc;
	logic [prm_pkg::ALARM_W-1:0] alarm_next;
	logic [15:0]        hold_next;

	assign in_xfer   = in_valid && in_ready;
	assign out_load  = (state_q == prm_pkg::ST_WRITE) && (!out_valid_q || out_ready);
	assign bit_sum   = {1'b0, bit_total_q} + (BT_W + 1)'(len_q);
	assign ibits_sum = {1'b0, ibits_q} + (IBITS_W + 1)'(len_q);
	assign dur_calc  = (ts_q >= interval_start_q) ? ts_q - interval_start_q : '0;
	assign alarm_next = alarm_count_q + 1'b1;
	assign hold_next  = (hold_count_q == 16'hFFFF) ? hold_count_q : hold_count_q + 1'b1;

	always_comb begin
		unique case (sel_q)
			prm_pkg::RATE_BITS:    div_count = ibits_q;
			prm_pkg::RATE_PACKETS: div_count = IBITS_W'(ipackets_q);
			prm_pkg::RATE_MAL:     div_count = IBITS_W'(imal_q);
			prm_pkg::RATE_BEN:     div_count = IBITS_W'(iben_q);
			default:               div_count = '0;
		endcase
	end

	prm_rate_div #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_rate_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.count  (div_count),
		.dur    (dur_q),
		.done   (div_done),
		.result (div_result)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prm_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = prm_pkg::ST_EVAL;
			end
			prm_pkg::ST_EVAL:   state_d = prm_pkg::ST_DECIDE;
			prm_pkg::ST_DECIDE: state_d = close_q ? prm_pkg::ST_RATE_REQ : prm_pkg::ST_COUNT;
			prm_pkg::ST_RATE_REQ: state_d = prm_pkg::ST_RATE_WAIT;
			prm_pkg::ST_RATE_WAIT: begin
				if (div_done)
					state_d = (sel_q == prm_pkg::RATE_BEN) ? prm_pkg::ST_COUNT :
						prm_pkg::ST_RATE_REQ;
			end
			prm_pkg::ST_COUNT: state_d = prm_pkg::ST_CHECK;
			prm_pkg::ST_CHECK: state_d = prm_pkg::ST_WRITE;
			prm_pkg::ST_WRITE: begin
				if (!out_valid_q || out_ready)
					state_d = prm_pkg::ST_IDLE;
			end
			default: state_d = prm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == prm_pkg::ST_IDLE);
		div_req.start = (state_q == prm_pkg::ST_RATE_REQ);
		div_req.wide  = (sel_q == prm_pkg::RATE_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= prm_pkg::ST_IDLE;
			sel_q            <= prm_pkg::RATE_BITS;
			batch_size_q     <= prm_pkg::BATCH_SIZE_RST;
			max_interval_q   <= prm_pkg::MAX_INTERVAL_RST;
			threshold_pps_q  <= prm_pkg::THRESHOLD_PPS_RST;
			hold_intervals_q <= prm_pkg::HOLD_INTERVALS_RST;
			load_en_q        <= 1'b1;
			thresh_en_q      <= 1'b1;
			packet_total_q   <= '0;
			bit_total_q      <= '0;
			interval_start_q <= '0;
			ipackets_q       <= '0;
			imal_q           <= '0;
			iben_q           <= '0;
			ibits_q          <= '0;
			rate_packets_q   <= '0;
			rate_bits_q      <= '0;
			rate_mal_q       <= '0;
			rate_ben_q       <= '0;
			alarm_count_q    <= '0;
			alarm_latched_q  <= 1'b0;
			hold_count_q     <= '0;
			flag_value_q     <= 1'b0;
			close_q          <= 1'b0;
			prev_flag_q      <= 1'b0;
			event_q          <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_addr)
					prm_pkg::REG_BATCH_SIZE:     batch_size_q     <= cfg_wdata[15:0];
					prm_pkg::REG_MAX_INTERVAL:   max_interval_q   <= cfg_wdata;
					prm_pkg::REG_THRESHOLD_PPS:  threshold_pps_q  <= cfg_wdata;
					prm_pkg::REG_HOLD_INTERVALS: hold_intervals_q <= cfg_wdata[15:0];
					prm_pkg::REG_LOAD_ENABLE:    load_en_q        <= cfg_wdata[0];
					prm_pkg::REG_THRESH_ENABLE:  thresh_en_q      <= cfg_wdata[0];
					default: begin
					end
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				prm_pkg::ST_EVAL: begin
					if (packet_total_q != {prm_pkg::TOTAL_W{1'b1}})
						packet_total_q <= packet_total_q + 1'b1;
					bit_total_q <= bit_sum[BT_W] ? {BT_W{1'b1}} : bit_sum[BT_W-1:0];
					close_q <= (ipackets_q >= batch_size_q) ||
						(dur_calc >= TS_W'(max_interval_q));
				end
				prm_pkg::ST_DECIDE: begin
					sel_q   <= prm_pkg::RATE_BITS;
				end
				prm_pkg::ST_RATE_WAIT: begin
					if (div_done) begin
						unique case (sel_q)
							prm_pkg::RATE_BITS:    rate_bits_q    <= div_result;
							prm_pkg::RATE_PACKETS: rate_packets_q <= div_result[31:0];
							prm_pkg::RATE_MAL:     rate_mal_q     <= div_result[31:0];
							prm_pkg::RATE_BEN:     rate_ben_q     <= div_result[31:0];
							default: begin
							end
						endcase
						sel_q <= prm_pkg::rate_sel_t'(sel_q + 2'd1);
						if (sel_q == prm_pkg::RATE_BEN) begin
							interval_start_q <= ts_q;
							ipackets_q       <= '0;
							imal_q           <= '0;
							iben_q           <= '0;
							ibits_q          <= '0;
						end
					end
				end
				prm_pkg::ST_COUNT: begin
					if (!(&ipackets_q))
						ipackets_q <= ipackets_q + 1'b1;
					if (mal_q) begin
						if (!(&imal_q))
							imal_q <= imal_q + 1'b1;
					end else begin
						if (!(&iben_q))
							iben_q <= iben_q + 1'b1;
					end
					ibits_q <= ibits_sum[IBITS_W] ? {IBITS_W{1'b1}} : ibits_sum[IBITS_W-1:0];
				end
				prm_pkg::ST_CHECK: begin
					prev_flag_q <= flag_value_q;
					event_q     <= 1'b0;
					if (load_en_q && !alarm_latched_q && rate_packets_q >= prm_pkg::LOAD_RATE_MIN)
					begin
						alarm_count_q <= alarm_next;
						if (alarm_next == prm_pkg::LOAD_FIRE_COUNT) begin
							alarm_latched_q <= 1'b1;
							event_q         <= 1'b1;
						end
					end
					if (thresh_en_q) begin
						if (rate_packets_q > threshold_pps_q) begin
							hold_count_q <= hold_next;
							if (hold_next == hold_intervals_q)
								flag_value_q <= 1'b1;
						end else begin
							hold_count_q <= '0;
							flag_value_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ts_q  <= timestamp;
			len_q <= bit_length;
			mal_q <= is_malicious;
		end
		if (state_q == prm_pkg::ST_EVAL)
			dur_q <= dur_calc;
		if (out_load) begin
			total_packets_q  <= packet_total_q;
			total_bytes_q    <= bit_total_q[BT_W-1:3];
			current_pps_q    <= rate_packets_q;
			current_bps_q    <= rate_bits_q;
			malicious_pps_q  <= rate_mal_q;
			benign_pps_q     <= rate_ben_q;
			threshold_flag_q <= prev_flag_q;
			load_event_q     <= event_q;
			load_latched_q   <= alarm_latched_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign total_packets      = total_packets_q;
	assign total_bytes        = total_bytes_q;
	assign current_pps        = current_pps_q;
	assign current_bps        = current_bps_q;
	assign malicious_pps      = malicious_pps_q;
	assign benign_pps         = benign_pps_q;
	assign threshold_flag     = threshold_flag_q;
	assign load_event         = load_event_q;
	assign load_alarm_latched = load_latched_q;

`ifndef SYNTHESIS
	a_alarm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_count_q <= prm_pkg::LOAD_FIRE_COUNT)
		else $error("load alarm counter ran past its firing count");

	a_flag_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		flag_value_q |-> hold_count_q != '0)
		else $error("threshold flag set with a cleared hold counter");

	a_event_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && load_event |-> load_alarm_latched)
		else $error("load event reported without the latched alarm");

	a_rate_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> state_q == prm_pkg::ST_RATE_REQ && !div_done)
		else $error("rate unit started while finishing");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for packet_rate_monitor_alarm: a directed table, then random packet traffic
// with random stalls on both channels, each result transfer checked against the expected
// table row or a predictor. Depends on prm_pkg and the RTL of the block.
module tb;

	localparam longint unsigned TICKS = prm_pkg::TICKS_PER_SECOND_DEF;
	localparam int unsigned ALARM_RATE = 3000;
	localparam int unsigned ALARM_PACKETS = 100;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 160;
	localparam int HOLD_OFF_CYCLES = 600;

	typedef struct {
		logic [47:0] packets;
		logic [47:0] bytes;
		logic [31:0] pps;
		logic [39:0] bps;
		logic [31:0] mal_pps;
		logic [31:0] ben_pps;
		logic        flag;
		logic        load_evt;
		logic        latched;
	} pkt_out_t;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		prm_pkg::cfg_reg_t  addr;
		logic [31:0]        value;
		logic [47:0]        ts;
		logic [18:0]        len;
		logic               mal;
		bit                 typed;
		pkt_out_t           want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [prm_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [prm_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [prm_pkg::TS_W-1:0] timestamp;
	logic [prm_pkg::LEN_W-1:0] bit_length;
	logic is_malicious;
	logic out_valid;
	logic out_ready;
	logic [prm_pkg::TOTAL_W-1:0] total_packets;
	logic [prm_pkg::TOTAL_W-1:0] total_bytes;
	logic [prm_pkg::RATE_W-1:0] current_pps;
	logic [prm_pkg::RATE_WIDE-1:0] current_bps;
	logic [prm_pkg::RATE_W-1:0] malicious_pps;
	logic [prm_pkg::RATE_W-1:0] benign_pps;
	logic threshold_flag;
	logic load_event;
	logic load_alarm_latched;

	logic [15:0] cfg_batch;
	logic [31:0] cfg_max_iv;
	logic [31:0] cfg_thr;
	logic [15:0] cfg_hold;
	logic cfg_load_en;
	logic cfg_thr_en;

	logic [47:0] pkt_total;
	logic [50:0] bit_total;
	logic [47:0] iv_start;
	logic [15:0] iv_pkts;
	logic [15:0] iv_mal;
	logic [15:0] iv_ben;
	logic [35:0] iv_bits;
	logic [31:0] rate_pkts;
	logic [39:0] rate_bits;
	logic [31:0] rate_mal;
	logic [31:0] rate_ben;
	logic [6:0] alarm_cnt;
	logic alarm_latched;
	logic [15:0] hold_cnt;
	logic flag_val;

	pkt_out_t pending_results[$];
	plan_row_t directed_plan[$];
	int mismatch_count = 0;
	bit send_idle;
	bit recv_idle;
	bit hold_off_req;

	packet_rate_monitor_alarm dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [39:0] scaled_rate(logic [35:0] count, logic [47:0] span,
			logic [39:0] cap);
		logic [63:0] quot;
		if (count == '0)
			return '0;
		if (span == '0)
			return cap;
		quot = (64'(count) * TICKS) / 64'(span);
		return (quot > 64'(cap)) ? cap : quot[39:0];
	endfunction

	function automatic pkt_out_t predict_packet(logic [47:0] ts, logic [18:0] len, logic mal);
		pkt_out_t r;
		logic [47:0] span;
		logic [51:0] bit_sum;
		logic [36:0] iv_sum;
		logic prev_flag;
		span = (ts >= iv_start) ? ts - iv_start : '0;
		prev_flag = flag_val;
		r.load_evt = 1'b0;
		if (pkt_total != '1)
			pkt_total = pkt_total + 1'b1;
		bit_sum = {1'b0, bit_total} + 52'(len);
		bit_total = bit_sum[51] ? '1 : bit_sum[50:0];
		if (iv_pkts >= cfg_batch || span >= 48'(cfg_max_iv)) begin
			rate_bits = scaled_rate(iv_bits, span, 40'hFF_FFFF_FFFF);
			rate_pkts = 32'(scaled_rate(36'(iv_pkts), span, 40'h00_FFFF_FFFF));
			rate_mal = 32'(scaled_rate(36'(iv_mal), span, 40'h00_FFFF_FFFF));
			rate_ben = 32'(scaled_rate(36'(iv_ben), span, 40'h00_FFFF_FFFF));
			iv_start = ts;
			iv_pkts = '0;
			iv_mal = '0;
			iv_ben = '0;
			iv_bits = '0;
		end
		if (iv_pkts != '1)
			iv_pkts = iv_pkts + 1'b1;
		if (mal) begin
			if (iv_mal != '1)
				iv_mal = iv_mal + 1'b1;
		end else begin
			if (iv_ben != '1)
				iv_ben = iv_ben + 1'b1;
		end
		iv_sum = {1'b0, iv_bits} + 37'(len);
		iv_bits = iv_sum[36] ? '1 : iv_sum[35:0];
		if (cfg_load_en && !alarm_latched && rate_pkts >= ALARM_RATE) begin
			alarm_cnt = alarm_cnt + 1'b1;
			if (alarm_cnt == ALARM_PACKETS) begin
				alarm_latched = 1'b1;
				r.load_evt = 1'b1;
			end
		end
		if (cfg_thr_en) begin
			if (rate_pkts > cfg_thr) begin
				if (hold_cnt != '1)
					hold_cnt = hold_cnt + 1'b1;
				if (hold_cnt == cfg_hold)
					flag_val = 1'b1;
			end else begin
				hold_cnt = '0;
				flag_val = 1'b0;
			end
		end
		r.packets = pkt_total;
		r.bytes = bit_total[50:3];
		r.pps = rate_pkts;
		r.bps = rate_bits;
		r.mal_pps = rate_mal;
		r.ben_pps = rate_ben;
		r.flag = prev_flag;
		r.latched = alarm_latched;
		return r;
	endfunction

	function automatic plan_row_t blank_row();
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.addr = prm_pkg::REG_BATCH_SIZE;
		row.value = '0;
		row.ts = '0;
		row.len = '0;
		row.mal = 1'b0;
		row.typed = 1'b0;
		row.want = '{default: '0};
		return row;
	endfunction

	function automatic void add_packet(logic [47:0] ts, logic [18:0] len, logic mal);
		plan_row_t row;
		row = blank_row();
		row.kind = ROW_ITEM;
		row.ts = ts;
		row.len = len;
		row.mal = mal;
		directed_plan.insert(directed_plan.size(), row);
	endfunction

	function automatic void add_checked(logic [47:0] ts, logic [18:0] len, logic mal,
			pkt_out_t want);
		plan_row_t row;
		row = blank_row();
		row.kind = ROW_ITEM;
		row.ts = ts;
		row.len = len;
		row.mal = mal;
		row.typed = 1'b1;
		row.want = want;
		directed_plan.insert(directed_plan.size(), row);
	endfunction

	function automatic void add_write(prm_pkg::cfg_reg_t addr, logic [31:0] value);
		plan_row_t row;
		row = blank_row();
		row.kind = ROW_CFG;
		row.addr = addr;
		row.value = value;
		directed_plan.insert(directed_plan.size(), row);
	endfunction

	task automatic write_reg(prm_pkg::cfg_reg_t addr, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		case (addr)
			prm_pkg::REG_BATCH_SIZE:     cfg_batch = value[15:0];
			prm_pkg::REG_MAX_INTERVAL:   cfg_max_iv = value;
			prm_pkg::REG_THRESHOLD_PPS:  cfg_thr = value;
			prm_pkg::REG_HOLD_INTERVALS: cfg_hold = value[15:0];
			prm_pkg::REG_LOAD_ENABLE:    cfg_load_en = value[0];
			prm_pkg::REG_THRESH_ENABLE:  cfg_thr_en = value[0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_packet(plan_row_t row);
		int unsigned gap;
		pkt_out_t predicted;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		timestamp <= row.ts;
		bit_length <= row.len;
		is_malicious <= row.mal;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = predict_packet(row.ts, row.len, row.mal);
		pending_results.insert(pending_results.size(), row.typed ? row.want : predicted);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		plan_row_t row;
		logic [47:0] ts_now;
		int unsigned pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		timestamp = '0;
		bit_length = '0;
		is_malicious = 1'b0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_off_req = 1'b0;
		cfg_batch = 16'd10;
		cfg_max_iv = 32'd100000;
		cfg_thr = 32'd100;
		cfg_hold = 16'd100;
		cfg_load_en = 1'b1;
		cfg_thr_en = 1'b1;
		pkt_total = '0;
		bit_total = '0;
		iv_start = '0;
		iv_pkts = '0;
		iv_mal = '0;
		iv_ben = '0;
		iv_bits = '0;
		rate_pkts = '0;
		rate_bits = '0;
		rate_mal = '0;
		rate_ben = '0;
		alarm_cnt = '0;
		alarm_latched = 1'b0;
		hold_cnt = '0;
		flag_val = 1'b0;

		add_checked(48'd0, 19'd0, 1'b0,
			'{48'd1, 48'd0, 32'd0, 40'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0});
		add_checked(48'd0, 19'h7FFFF, 1'b1,
			'{48'd2, 48'd65535, 32'd0, 40'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0});
		add_checked(48'd0, 19'h7FFFF, 1'b0,
			'{48'd3, 48'd131071, 32'd0, 40'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0});
		add_write(prm_pkg::REG_BATCH_SIZE, 32'd0);
		add_packet(48'd0, 19'd16, 1'b1);
		add_packet(48'd10, 19'd8, 1'b0);
		add_write(prm_pkg::REG_BATCH_SIZE, 32'd65535);
		add_write(prm_pkg::REG_MAX_INTERVAL, 32'd1);
		add_packet(48'd10, 19'h7FFFF, 1'b1);
		add_packet(48'd10, 19'h7FFFF, 1'b0);
		add_packet(48'd11, 19'h7FFFF, 1'b1);
		add_packet(48'd5, 19'd100, 1'b0);
		add_write(prm_pkg::REG_MAX_INTERVAL, 32'hFFFF_FFFF);
		add_write(prm_pkg::REG_THRESHOLD_PPS, 32'd0);
		add_write(prm_pkg::REG_HOLD_INTERVALS, 32'd1);
		add_packet(48'd100, 19'd1, 1'b0);
		add_packet(48'hFFFF_FFFF_FFFF, 19'h7FFFF, 1'b1);
		add_packet(48'd0, 19'd0, 1'b0);
		add_write(prm_pkg::REG_BATCH_SIZE, 32'd1);
		add_write(prm_pkg::REG_MAX_INTERVAL, 32'd100000);
		add_write(prm_pkg::REG_THRESHOLD_PPS, 32'd100);
		add_write(prm_pkg::REG_HOLD_INTERVALS, 32'd0);
		add_packet(48'd1, 19'd3, 1'b1);
		add_packet(48'd2, 19'd5, 1'b0);
		add_write(prm_pkg::REG_LOAD_ENABLE, 32'd0);
		add_write(prm_pkg::REG_THRESH_ENABLE, 32'd0);
		add_write(prm_pkg::REG_THRESHOLD_PPS, 32'hFFFF_FFFF);
		add_write(prm_pkg::REG_HOLD_INTERVALS, 32'd65535);
		add_packet(48'd3, 19'd7, 1'b1);
		add_packet(48'd3, 19'd9, 1'b0);
		add_write(prm_pkg::REG_LOAD_ENABLE, 32'd1);
		add_write(prm_pkg::REG_THRESH_ENABLE, 32'd1);
		add_write(prm_pkg::REG_THRESHOLD_PPS, 32'd1000);
		add_write(prm_pkg::REG_HOLD_INTERVALS, 32'd2);
		add_write(prm_pkg::REG_BATCH_SIZE, 32'd2);
		add_write(prm_pkg::REG_MAX_INTERVAL, 32'd1000);
		add_packet(48'd4, 19'd100, 1'b0);
		add_packet(48'd5, 19'd200, 1'b1);
		add_packet(48'd6, 19'd300, 1'b0);
		add_packet(48'd2000, 19'd400, 1'b1);
		add_packet(48'd2001, 19'd500, 1'b0);
		add_packet(48'd2002, 19'd600, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG) begin
				if (i > 0 && directed_plan[i-1].kind == ROW_ITEM)
					drain_results();
				write_reg(directed_plan[i].addr, directed_plan[i].value);
			end else begin
				if (i > 0 && directed_plan[i-1].kind == ROW_CFG)
					close_writes();
				send_packet(directed_plan[i]);
			end
		end
		drain_results();

		// Each phase writes all registers while the block is idle, then runs packet
		// traffic with a nondecreasing clock plus occasional backward timestamps.
		row = blank_row();
		row.kind = ROW_ITEM;
		ts_now = 48'd5000;
		for (int p = 0; p < PHASES; p++) begin
			send_idle = (p % 4 == 0) || (p % 4 == 2);
			recv_idle = (p % 4 == 0) || (p % 4 == 1);
			pick = $urandom_range(0, 5);
			write_reg(prm_pkg::REG_BATCH_SIZE, pick == 0 ? 32'd1 : pick == 1 ? 32'd65535 :
				32'($urandom_range(2, 12)));
			pick = $urandom_range(0, 3);
			write_reg(prm_pkg::REG_MAX_INTERVAL, pick == 0 ? 32'd1 :
				pick == 1 ? 32'hFFFF_FFFF : 32'($urandom_range(20, 3000)));
			pick = $urandom_range(0, 4);
			write_reg(prm_pkg::REG_THRESHOLD_PPS, pick == 0 ? 32'd0 :
				pick == 1 ? 32'hFFFF_FFFF :
				pick == 2 ? 32'($urandom()) : 32'($urandom_range(1000, 300000)));
			pick = $urandom_range(0, 3);
			write_reg(prm_pkg::REG_HOLD_INTERVALS, pick == 0 ? 32'd1 :
				pick == 1 ? 32'd65535 : 32'($urandom_range(2, 8)));
			write_reg(prm_pkg::REG_LOAD_ENABLE, 32'($urandom_range(0, 3) != 0));
			write_reg(prm_pkg::REG_THRESH_ENABLE, 32'($urandom_range(0, 3) != 0));
			close_writes();
			if (p == 1)
				hold_off_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					row.ts = (ts_now > 48'd500) ? ts_now - 48'($urandom_range(1, 500)) : ts_now;
				end else begin
					if (pick < 8)
						ts_now = ts_now + 48'($urandom_range(0, 200000));
					else if (pick >= 20)
						ts_now = ts_now + 48'($urandom_range(1, 40));
					row.ts = ts_now;
				end
				pick = $urandom_range(0, 9);
				row.len = pick == 0 ? 19'd0 : pick == 1 ? 19'h7FFFF :
					19'($urandom_range(0, 524287));
				row.mal = 1'($urandom_range(0, 1));
				send_packet(row);
			end
			drain_results();
		end

		repeat (300) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				stall = recv_idle ? $urandom_range(0, 15) : 0;
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	always @(posedge clk) begin
		pkt_out_t got;
		pkt_out_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{total_packets, total_bytes, current_pps, current_bps, malicious_pps,
				benign_pps, threshold_flag, load_event, load_alarm_latched};
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: result transfer with no packet pending", $time);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.packets !== want.packets || got.bytes !== want.bytes ||
						got.pps !== want.pps || got.bps !== want.bps ||
						got.mal_pps !== want.mal_pps || got.ben_pps !== want.ben_pps ||
						got.flag !== want.flag || got.load_evt !== want.load_evt ||
						got.latched !== want.latched) begin
					if (mismatch_count < 10) begin
						$display("%0t: want pkts=%0d bytes=%0d pps=%0d bps=%0d",
							$time, want.packets, want.bytes, want.pps, want.bps);
						$display("      want mal=%0d ben=%0d flag=%b evt=%b latch=%b",
							want.mal_pps, want.ben_pps, want.flag, want.load_evt,
							want.latched);
						$display("%0t: got  pkts=%0d bytes=%0d pps=%0d bps=%0d",
							$time, got.packets, got.bytes, got.pps, got.bps);
						$display("      got  mal=%0d ben=%0d flag=%b evt=%b latch=%b",
							got.mal_pps, got.ben_pps, got.flag, got.load_evt,
							got.latched);
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#60000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/prm_pkg.sv
rtl/prm_rate_div.sv
rtl/packet_rate_monitor_alarm.sv
verif/tb.sv
